// ----- rtl/crtc_pkg.sv -----
package crtc_pkg;

    // status B bits and hour byte fields
    localparam int unsigned BIT_BINARY = 2;
    localparam int unsigned BIT_H24    = 1;
    localparam int unsigned BIT_PM     = 7;

    localparam logic [7:0] CENTURY_DEFAULT = 8'd20;   // century byte of zero means 20xx
    localparam logic [8:0] CENTURY_MIN     = 9'd20;   // earliest accepted year is 2020
    localparam logic [6:0] YEAR_MIN        = 7'd20;

    // input word: one snapshot of the RTC registers
    typedef struct packed {
        logic [7:0] raw_second;
        logic [7:0] raw_minute;
        logic [7:0] raw_hour;
        logic [7:0] raw_day;
        logic [7:0] raw_month;
        logic [7:0] raw_year;
        logic [7:0] raw_century;
        logic [7:0] mode_byte;
    } t_in_word;

    // output word
    typedef struct packed {
        logic        valid_res;
        logic [23:0] day_count;
        logic [16:0] second_count;
    } t_out_word;

    // decoded snapshot; full year = 100 * cent_q + year_r, year_r below 100.
    // Narrow fields only meaningful when ok is set.
    typedef struct packed {
        logic       ok;
        logic [8:0] cent_q;
        logic [6:0] year_r;
        logic [3:0] month;
        logic [4:0] day;
        logic [4:0] hour;
        logic [5:0] minute;
        logic [5:0] second;
    } t_dec;

    // days before the first of each month in a common year
    function automatic logic [8:0] month_start(input logic [3:0] idx);
        logic [8:0] v;
        unique case (idx)
            4'd0:    v = 9'd0;
            4'd1:    v = 9'd31;
            4'd2:    v = 9'd59;
            4'd3:    v = 9'd90;
            4'd4:    v = 9'd120;
            4'd5:    v = 9'd151;
            4'd6:    v = 9'd181;
            4'd7:    v = 9'd212;
            4'd8:    v = 9'd243;
            4'd9:    v = 9'd273;
            4'd10:   v = 9'd304;
            4'd11:   v = 9'd334;
            default: v = 9'd0;
        endcase
        return v;
    endfunction

endpackage

// ----- rtl/cmos_rtc_to_day_count.sv -----
// Channel | Direction | Handshake                 | Word
// --------+-----------+---------------------------+--------------------------------
// in      | in        | i_in_valid / o_in_ready   | i_in_word  (raw RTC snapshot)
// out     | out       | o_out_valid / i_out_ready | o_out_word (valid, days, secs)
//
// A word taken into the input register moves on to the result register when the
// result stage is free or draining. One word a cycle sustained while the output is
// not stalled; the whole conversion is one combinational pass between the two.
// Synchronous active-low reset empties both stages and zeroes the held results.
// A stalled output holds the result register; the input register still takes a
// word if empty, then o_in_ready drops until the result moves on.
module cmos_rtc_to_day_count (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  crtc_pkg::t_in_word  i_in_word,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output crtc_pkg::t_out_word o_out_word
);
    import crtc_pkg::*;

    // input stage
    logic     r_in_vld;
    t_in_word r_in_word;

    // result stage and last valid conversion
    logic        r_out_vld;
    t_out_word   r_out_word;
    logic [23:0] r_held_days;
    logic [16:0] r_held_secs;

    t_dec        dec;
    logic [23:0] days;
    logic [16:0] secs;
    logic        advance;
    t_out_word   n_out_word;

    // result stage free or draining this cycle
    assign advance    = !r_out_vld || i_out_ready;
    assign o_in_ready = !r_in_vld || advance;

    crtc_decode u_decode (
        .i_word (r_in_word),
        .o_dec  (dec)
    );

    crtc_days u_days (
        .i_dec  (dec),
        .o_days (days),
        .o_secs (secs)
    );

    // a failed snapshot repeats what was last held
    always_comb begin
        n_out_word.valid_res    = dec.ok;
        n_out_word.day_count    = dec.ok ? days : r_held_days;
        n_out_word.second_count = dec.ok ? secs : r_held_secs;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld    <= 1'b0;
            r_out_vld   <= 1'b0;
            r_held_days <= '0;
            r_held_secs <= '0;
        end else begin
            if (o_in_ready) begin
                r_in_vld <= i_in_valid;
            end
            if (advance) begin
                r_out_vld <= r_in_vld;
            end
            if (advance && r_in_vld && dec.ok) begin
                r_held_days <= days;
                r_held_secs <= secs;
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_word <= i_in_word;
        end
        if (advance && r_in_vld) begin
            r_out_word <= n_out_word;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_word  = r_out_word;

`ifndef SYNTHESIS
    // a pending result always mirrors the held values
    a_out_matches_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld |-> (r_out_word.day_count == r_held_days)
                      && (r_out_word.second_count == r_held_secs))
        else $error("result word differs from held values");

    // a blocked result keeps the input stage occupied
    a_in_stage_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && !i_out_ready && r_in_vld) |=> r_in_vld)
        else $error("input stage dropped a word under stall");

    // seconds of day never exceed 86400, reached only at a leap second 23:59:60
    a_secs_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld |-> (r_out_word.second_count <= 17'd86400))
        else $error("second count out of range");
`endif

endmodule

// ----- rtl/crtc_decode.sv -----
module crtc_decode (
    input  crtc_pkg::t_in_word i_word,
    output crtc_pkg::t_dec     o_dec
);
    import crtc_pkg::*;

    // nibbles above 9 pass through unchecked
    function automatic logic [7:0] from_bcd(input logic [7:0] v);
        return {4'd0, v[3:0]} + {1'b0, v[7:4], 3'd0} + {3'd0, v[7:4], 1'b0};
    endfunction

    logic [7:0] sec, min, hour, day, mon, yr, cent;
    logic [7:0] hour_bcd;
    logic [7:0] hour24, hour_lo, cent_eff;
    logic [6:0] yr_r;
    logic [1:0] yr_q;
    logic [8:0] cent_q;
    logic       year_ok;

    always_comb begin
        hour_bcd = from_bcd({1'b0, i_word.raw_hour[6:0]});
        if (!i_word.mode_byte[BIT_BINARY]) begin
            sec  = from_bcd(i_word.raw_second);
            min  = from_bcd(i_word.raw_minute);
            hour = {i_word.raw_hour[BIT_PM], hour_bcd[6:0]};
            day  = from_bcd(i_word.raw_day);
            mon  = from_bcd(i_word.raw_month);
            yr   = from_bcd(i_word.raw_year);
            cent = from_bcd(i_word.raw_century);
        end else begin
            sec  = i_word.raw_second;
            min  = i_word.raw_minute;
            hour = i_word.raw_hour;
            day  = i_word.raw_day;
            mon  = i_word.raw_month;
            yr   = i_word.raw_year;
            cent = i_word.raw_century;
        end
    end

    // 12-hour: noon/midnight 12 reads as 0, then PM adds 12; no wrap
    always_comb begin
        hour_lo = {1'b0, hour[6:0]};
        if (hour_lo == 8'd12) begin
            hour_lo = 8'd0;
        end
        if (i_word.mode_byte[BIT_H24]) begin
            hour24 = hour;
        end else if (hour[BIT_PM]) begin
            hour24 = hour_lo + 8'd12;
        end else begin
            hour24 = hour_lo;
        end
    end

    // fold the year byte's hundreds into the century
    always_comb begin
        cent_eff = (cent == 8'd0) ? CENTURY_DEFAULT : cent;
        priority if (yr >= 8'd200) begin
            yr_q = 2'd2;
            yr_r = 7'(yr - 8'd200);
        end else if (yr >= 8'd100) begin
            yr_q = 2'd1;
            yr_r = 7'(yr - 8'd100);
        end else begin
            yr_q = 2'd0;
            yr_r = yr[6:0];
        end
        cent_q  = {1'b0, cent_eff} + {7'd0, yr_q};
        year_ok = (cent_q > CENTURY_MIN) || ((cent_q == CENTURY_MIN) && (yr_r >= YEAR_MIN));
    end

    always_comb begin
        o_dec.ok     = year_ok && (mon >= 8'd1) && (mon <= 8'd12)
                       && (day >= 8'd1) && (day <= 8'd31)
                       && (hour24 <= 8'd23) && (min <= 8'd59) && (sec <= 8'd60);
        o_dec.cent_q = cent_q;
        o_dec.year_r = yr_r;
        o_dec.month  = mon[3:0];
        o_dec.day    = day[4:0];
        o_dec.hour   = hour24[4:0];
        o_dec.minute = min[5:0];
        o_dec.second = sec[5:0];
    end

endmodule

// ----- rtl/crtc_days.sv -----
module crtc_days (
    input  crtc_pkg::t_dec  i_dec,
    output logic [23:0]     o_days,
    output logic [16:0]     o_secs
);
    import crtc_pkg::*;

    logic [23:0] c24, r24, q24, r_quarter, days_year, days_month;
    logic        r_nz, adj400, leap, leap_add;

    // year = 100*C + r, r < 100, C = 4q + m:
    //   365y + ceil(y/4) - ceil(y/100) + ceil(y/400)
    //   = 36524C + 365r + ceil(r/4) - [r!=0] + q + [100m+r != 0]
    always_comb begin
        c24       = {15'd0, i_dec.cent_q};
        r24       = {17'd0, i_dec.year_r};
        q24       = {17'd0, i_dec.cent_q[8:2]};
        r_nz      = (i_dec.year_r != 7'd0);
        adj400    = r_nz || (i_dec.cent_q[1:0] != 2'd0);
        r_quarter = (r24 + 24'd3) >> 2;
        days_year = c24 * 24'd36524 + r24 * 24'd365 + r_quarter + q24
                    + {23'd0, adj400} - {23'd0, r_nz};

        leap      = (r_nz && (i_dec.year_r[1:0] == 2'd0))
                    || (!r_nz && (i_dec.cent_q[1:0] == 2'd0));
        leap_add  = leap && (i_dec.month > 4'd2);
        days_month = {15'd0, month_start(i_dec.month - 4'd1)};

        o_days = days_year + days_month + {23'd0, leap_add}
                 + {19'd0, i_dec.day} - 24'd1;
        o_secs = {12'd0, i_dec.hour} * 17'd3600 + {11'd0, i_dec.minute} * 17'd60
                 + {11'd0, i_dec.second};
    end

endmodule
